// ----- hw/rtl/infix_to_postfix_converter_core_assert.svh -----
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core_assert.svh
// assertion macros shared by the converter rtl
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define I2P_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define I2P_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/i2p_pkg.sv -----
// ----------------------------------------------------------------------------
// i2p_pkg
// token codes, result codes and shared types of the infix to postfix converter
// ----------------------------------------------------------------------------
package i2p_pkg;

	localparam int ENTRY_W   = 3;
	localparam int PRIO_W    = 4;
	localparam int OPC_W     = 2;
	localparam int NUM_OPS   = 4;
	localparam int REG_IDX_W = 2;

	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [PRIO_W-1:0]  prio_t;

	// stack entry marking a left paren, operators use codes below it
	localparam entry_t PAREN_MARK = 3'd4;

	localparam prio_t PRIO_RST [NUM_OPS] = '{4'd1, 4'd1, 4'd2, 4'd2};

	typedef enum logic [2:0] {
		MODE_VALUE  = 3'd0,
		MODE_OPER   = 3'd1,
		MODE_LPAREN = 3'd2,
		MODE_RPAREN = 3'd3,
		MODE_END    = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		KIND_VALUE  = 3'd0,
		KIND_OPER   = 3'd1,
		KIND_LPAREN = 3'd2,
		KIND_END    = 3'd3,
		KIND_ERROR  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_OVERFLOW  = 2'd1,
		ERR_UNMATCHED = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		kind_t            kind;
		logic [OPC_W-1:0] op;
		err_t             err;
	} res_t;

	typedef struct packed {
		logic emit;
		logic flush;
	} oq_ctl_t;

	typedef struct packed {
		logic out_free;
		logic pend_v;
	} oq_sts_t;

endpackage

// ----- hw/rtl/i2p_stack_mem.sv -----
// ----------------------------------------------------------------------------
// i2p_stack_mem
// operator stack storage, one write and one registered read port
// ----------------------------------------------------------------------------
module i2p_stack_mem #(
	parameter int DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  i2p_pkg::entry_t           wdata,
	input  logic                      re,
	input  logic [$clog2(DEPTH)-1:0]  raddr,
	output i2p_pkg::entry_t           rdata
);
	import i2p_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/i2p_out_q.sv -----
// ----------------------------------------------------------------------------
// i2p_out_q
// holds the newest result until the next one is known, then the output word
// ----------------------------------------------------------------------------
module i2p_out_q #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  i2p_pkg::oq_ctl_t           ctl,
	input  i2p_pkg::res_t              res,
	input  logic [VALUE_WIDTH-1:0]     res_value,
	output i2p_pkg::oq_sts_t           sts,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [2:0]                 out_kind,
	output logic [VALUE_WIDTH-1:0]     out_value,
	output logic [1:0]                 out_operator,
	output logic [1:0]                 error_code,
	output logic                       last_of_run
);
	import i2p_pkg::*;

	logic                   pend_v_q;
	res_t                   pend_q;
	logic [VALUE_WIDTH-1:0] pend_val_q;
	logic                   out_v_q;
	res_t                   out_res_q;
	logic [VALUE_WIDTH-1:0] out_val_q;
	logic                   out_last_q;
	logic                   load;

	// a new result pushes the held one out, end of item pushes it out as last
	assign load = (ctl.emit && pend_v_q) || ctl.flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (ctl.emit) begin
				pend_v_q <= 1'b1;
			end else if (ctl.flush) begin
				pend_v_q <= 1'b0;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			pend_q     <= res;
			pend_val_q <= res_value;
		end
		if (load) begin
			out_res_q  <= pend_q;
			out_val_q  <= pend_val_q;
			out_last_q <= ctl.flush;
		end
	end

	assign sts.out_free = !out_v_q || !out_stall;
	assign sts.pend_v   = pend_v_q;

	assign out_valid    = out_v_q;
	assign out_kind     = out_res_q.kind;
	assign out_value    = out_val_q;
	assign out_operator = out_res_q.op;
	assign error_code   = out_res_q.err;
	assign last_of_run  = out_last_q;

endmodule

// ----- hw/rtl/infix_to_postfix_converter_core.sv -----
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// shunting-yard converter from infix tokens to postfix words
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall carry one token (mode, operand_value,
// operator_code). output channel: out_valid / out_stall carry one result word,
// last_of_run marks the final word caused by a token.
// priorities are written through cfg_wr_en / cfg_index / cfg_data; the user
// must write them only while idle, the block does not enforce it. each result
// word is held until the next one is known, and the last word of a token is
// pushed out by a flush. a pop reads the next top of stack, which is
// forwarded when it returns, so pops add no bubble. the first word of a token
// passes the token registers, the held result and the output word before it
// shows, and later still when the receiver stalls. a new token is taken only
// once the previous one is done.
// reset empties the stack and loads the default priorities; stack entries
// are not cleared and no clearing pass runs.
// when the receiver stalls, the output word holds and the sequencer waits
// once one further result is held; no token is taken while the last word of
// the previous token is held.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core #(
	parameter int STACK_DEPTH = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [i2p_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [i2p_pkg::PRIO_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [2:0]                      mode,
	input  logic [VALUE_WIDTH-1:0]          operand_value,
	input  logic [i2p_pkg::OPC_W-1:0]       operator_code,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      out_kind,
	output logic [VALUE_WIDTH-1:0]          out_value,
	output logic [i2p_pkg::OPC_W-1:0]       out_operator,
	output logic [1:0]                      error_code,
	output logic                            last_of_run
);
	import i2p_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

	state_t                 state_q;
	state_t                 state_d;
	prio_t                  prio_q [NUM_OPS];
	mode_t                  mode_q;
	logic [OPC_W-1:0]       opc_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          below2;
	entry_t                 top_q;
	entry_t                 top_now;
	entry_t                 rd_data;
	logic                   ld_pend_q;
	logic                   in_acc;
	logic                   cnt_nz;
	logic                   full;
	logic                   top_paren;
	logic                   pops_top;

	logic                   emit_raw;
	logic                   push_raw;
	logic                   pop_raw;
	logic                   done;
	logic                   flush;
	entry_t                 push_code;
	res_t                   res;
	logic [VALUE_WIDTH-1:0] res_val;
	logic                   hold;
	logic                   emit;
	logic                   push;
	logic                   pop;
	logic                   fin;
	logic                   mem_re;
	oq_ctl_t                oq_ctl;
	oq_sts_t                oq_sts;

	assign in_acc    = in_valid && !in_stall;
	assign cnt_nz    = (count_q != '0);
	assign full      = (count_q == FULL);
	// forward the stack read that follows a pop
	assign top_now   = ld_pend_q ? rd_data : top_q;
	assign top_paren = (top_now == PAREN_MARK);
	assign pops_top  = cnt_nz && !top_paren &&
		(prio_q[top_now[OPC_W-1:0]] >= prio_q[opc_q]);

	// sequencer outputs and per-token decisions
	always_comb begin
		emit_raw  = 1'b0;
		push_raw  = 1'b0;
		pop_raw   = 1'b0;
		done      = 1'b0;
		flush     = 1'b0;
		in_stall  = 1'b1;
		push_code = PAREN_MARK;
		res       = '{kind: KIND_VALUE, op: '0, err: ERR_NONE};
		res_val   = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_FLUSH: begin
				in_stall = !oq_sts.out_free;
				flush    = oq_sts.out_free;
			end
			ST_RUN: begin
				unique case (mode_q)
					MODE_VALUE: begin
						emit_raw = 1'b1;
						res_val  = val_q;
						done     = 1'b1;
					end
					MODE_OPER: begin
						if (pops_top) begin
							emit_raw = 1'b1;
							res.kind = KIND_OPER;
							res.op   = top_now[OPC_W-1:0];
							pop_raw  = 1'b1;
						end else if (full) begin
							emit_raw = 1'b1;
							res.kind = KIND_ERROR;
							res.err  = ERR_OVERFLOW;
							done     = 1'b1;
						end else begin
							push_raw  = 1'b1;
							push_code = {1'b0, opc_q};
							done      = 1'b1;
						end
					end
					MODE_LPAREN: begin
						if (full) begin
							emit_raw = 1'b1;
							res.kind = KIND_ERROR;
							res.err  = ERR_OVERFLOW;
						end else begin
							push_raw = 1'b1;
						end
						done = 1'b1;
					end
					MODE_RPAREN: begin
						if (!cnt_nz) begin
							emit_raw = 1'b1;
							res.kind = KIND_ERROR;
							res.err  = ERR_UNMATCHED;
							done     = 1'b1;
						end else if (top_paren) begin
							pop_raw = 1'b1;
							done    = 1'b1;
						end else begin
							emit_raw = 1'b1;
							res.kind = KIND_OPER;
							res.op   = top_now[OPC_W-1:0];
							pop_raw  = 1'b1;
						end
					end
					MODE_END: begin
						emit_raw = 1'b1;
						if (!cnt_nz) begin
							res.kind = KIND_END;
							done     = 1'b1;
						end else if (top_paren) begin
							res.kind = KIND_LPAREN;
							pop_raw  = 1'b1;
						end else begin
							res.kind = KIND_OPER;
							res.op   = top_now[OPC_W-1:0];
							pop_raw  = 1'b1;
						end
					end
					default: begin
						done = 1'b1;
					end
				endcase
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// wait while a new result would overwrite a held one
	assign hold = emit_raw && oq_sts.pend_v && !oq_sts.out_free;
	assign emit = emit_raw && !hold;
	assign push = push_raw && !hold;
	assign pop  = pop_raw && !hold;
	assign fin  = done && !hold;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (fin) begin
					state_d = (oq_sts.pend_v || emit) ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (in_acc) begin
					state_d = ST_RUN;
				end else if (oq_sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign below2 = count_q - CW'(2);
	assign mem_re = pop && (count_q >= CW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			ld_pend_q <= 1'b0;
			for (int i = 0; i < NUM_OPS; i++) begin
				prio_q[i] <= PRIO_RST[i];
			end
		end else begin
			state_q   <= state_d;
			ld_pend_q <= mem_re;
			if (push) begin
				count_q <= count_q + CW'(1);
			end else if (pop) begin
				count_q <= count_q - CW'(1);
			end
			if (cfg_wr_en) begin
				prio_q[cfg_index] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= push ? push_code : top_now;
		if (in_acc) begin
			mode_q <= mode_t'(mode);
			opc_q  <= operator_code;
			val_q  <= operand_value;
		end
	end

	i2p_stack_mem #(
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (push),
		.waddr (count_q[AW-1:0]),
		.wdata (push_code),
		.re    (mem_re),
		.raddr (below2[AW-1:0]),
		.rdata (rd_data)
	);

	assign oq_ctl.emit  = emit;
	assign oq_ctl.flush = flush;

	i2p_out_q #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_out_q (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (oq_ctl),
		.res          (res),
		.res_value    (res_val),
		.sts          (oq_sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_kind     (out_kind),
		.out_value    (out_value),
		.out_operator (out_operator),
		.error_code   (error_code),
		.last_of_run  (last_of_run)
	);

`include "infix_to_postfix_converter_core_assert.svh"

	`I2P_ASSERT_SAME(a_mem_port_excl, mem_re, !push, "stack read and write in one cycle")
	`I2P_ASSERT_SAME(a_pop_nonempty, pop, cnt_nz, "pop from empty stack")
	`I2P_ASSERT_NEXT(a_accept_clean, in_acc, !oq_sts.pend_v, "held word left at token start")
	`I2P_ASSERT_NEXT(a_pop_count, pop, count_q == $past(count_q) - CW'(1), "count missed a pop")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// infix to postfix converter: a short table of directed tokens, then random
// expressions mixed with broken ones, deep nesting and noise, over several
// priority settings; each result word is checked against a fixed table word or
// a shunting-yard predictor that tracks its own operator stack and priorities
// ----------------------------------------------------------------------------
module testbench;
	import i2p_pkg::*;

	localparam int STACK_DEPTH     = 16;
	localparam int VALUE_W         = 32;
	localparam int WORDS_PER_PHASE = 40;
	localparam int NUM_PHASES      = 5;
	localparam int HOLD_CYCLES     = 400;
	localparam int SETTLE_CYCLES   = 12;
	localparam int MAX_GAP         = 12;

	localparam logic [REG_IDX_W-1:0] REG_ADD = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SUB = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MUL = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_DIV = 2'd3;

	localparam logic [OPC_W-1:0] OP_ADD = 2'd0;
	localparam logic [OPC_W-1:0] OP_SUB = 2'd1;
	localparam logic [OPC_W-1:0] OP_MUL = 2'd2;
	localparam logic [OPC_W-1:0] OP_DIV = 2'd3;

	// token kinds the block ignores
	localparam logic [2:0] MODE_RSVD5 = 3'd5;
	localparam logic [2:0] MODE_RSVD6 = 3'd6;
	localparam logic [2:0] MODE_RSVD7 = 3'd7;

	typedef struct {
		kind_t              kind;
		logic [VALUE_W-1:0] value;
		logic [OPC_W-1:0]   op;
		err_t               err;
		logic               last;
	} word_t;

	typedef struct {
		logic [2:0]         mode;
		logic [VALUE_W-1:0] value;
		logic [OPC_W-1:0]   opc;
		bit                 fixed;
		word_t              want;
	} token_t;

	typedef struct {
		token_t tok;
		int     reps;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [REG_IDX_W-1:0] cfg_index;
	prio_t                cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [2:0]           mode;
	logic [VALUE_W-1:0]   operand_value;
	logic [OPC_W-1:0]     operator_code;
	logic                 out_valid;
	logic                 out_stall;
	logic [2:0]           out_kind;
	logic [VALUE_W-1:0]   out_value;
	logic [OPC_W-1:0]     out_operator;
	logic [1:0]           error_code;
	logic                 last_of_run;

	token_t   cur_tok;
	entry_t   shunt_stack [STACK_DEPTH];
	int       shunt_depth;
	prio_t    prio_of [NUM_OPS];
	word_t    run_q [$];
	word_t    postfix_q [$];
	token_t   stim_q [$];
	dir_row_t dir_tab [25];
	int       live_cnt;
	int       err_cnt;
	bit       calm;
	bit       hold_req;

	infix_to_postfix_converter_core #(
		.STACK_DEPTH(STACK_DEPTH),
		.VALUE_WIDTH(VALUE_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.operand_value(operand_value),
		.operator_code(operator_code),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_kind     (out_kind),
		.out_value    (out_value),
		.out_operator (out_operator),
		.error_code   (error_code),
		.last_of_run  (last_of_run)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic word_t mk_word(kind_t k, logic [VALUE_W-1:0] v, logic [OPC_W-1:0] op,
			err_t e);
		word_t w;
		w.kind  = k;
		w.value = v;
		w.op    = op;
		w.err   = e;
		w.last  = 1'b0;
		return w;
	endfunction

	function automatic token_t mk_tok(logic [2:0] m, logic [VALUE_W-1:0] v, logic [OPC_W-1:0] opc);
		token_t t;
		t.mode  = m;
		t.value = v;
		t.opc   = opc;
		t.fixed = 1'b0;
		t.want  = mk_word(KIND_VALUE, '0, '0, ERR_NONE);
		return t;
	endfunction

	function automatic dir_row_t row(logic [2:0] m, logic [VALUE_W-1:0] v, logic [OPC_W-1:0] opc,
			int reps);
		dir_row_t r;
		r.tok  = mk_tok(m, v, opc);
		r.reps = reps;
		return r;
	endfunction

	// row whose single result word is known up front
	function automatic dir_row_t fixed_row(logic [2:0] m, logic [VALUE_W-1:0] v,
			logic [OPC_W-1:0] opc, kind_t k, err_t e);
		dir_row_t r;
		r.tok            = mk_tok(m, v, opc);
		r.tok.fixed      = 1'b1;
		r.tok.want       = mk_word(k, (k == KIND_VALUE) ? v : '0, '0, e);
		r.tok.want.last  = 1'b1;
		r.reps           = 1;
		return r;
	endfunction

	function automatic void push_entry(entry_t code);
		if (shunt_depth >= STACK_DEPTH) begin
			run_q.insert(run_q.size(), mk_word(KIND_ERROR, '0, '0, ERR_OVERFLOW));
		end else begin
			shunt_stack[shunt_depth] = code;
			shunt_depth++;
		end
	endfunction

	function automatic void shunt_token(token_t t);
		entry_t top;
		bit     paired;
		run_q.delete();
		case (t.mode)
			MODE_VALUE: run_q.insert(run_q.size(), mk_word(KIND_VALUE, t.value, '0, ERR_NONE));
			MODE_OPER: begin
				while (shunt_depth > 0) begin
					top = shunt_stack[shunt_depth-1];
					if (top >= PAREN_MARK || prio_of[top[OPC_W-1:0]] < prio_of[t.opc])
						break;
					run_q.insert(run_q.size(),
						mk_word(KIND_OPER, '0, top[OPC_W-1:0], ERR_NONE));
					shunt_depth--;
				end
				push_entry(entry_t'(t.opc));
			end
			MODE_LPAREN: push_entry(PAREN_MARK);
			MODE_RPAREN: begin
				paired = 1'b0;
				while (shunt_depth > 0) begin
					top = shunt_stack[shunt_depth-1];
					shunt_depth--;
					if (top >= PAREN_MARK) begin
						paired = 1'b1;
						break;
					end
					run_q.insert(run_q.size(),
						mk_word(KIND_OPER, '0, top[OPC_W-1:0], ERR_NONE));
				end
				if (!paired)
					run_q.insert(run_q.size(), mk_word(KIND_ERROR, '0, '0, ERR_UNMATCHED));
			end
			MODE_END: begin
				while (shunt_depth > 0) begin
					top = shunt_stack[shunt_depth-1];
					shunt_depth--;
					if (top >= PAREN_MARK)
						run_q.insert(run_q.size(), mk_word(KIND_LPAREN, '0, '0, ERR_NONE));
					else
						run_q.insert(run_q.size(),
							mk_word(KIND_OPER, '0, top[OPC_W-1:0], ERR_NONE));
				end
				run_q.insert(run_q.size(), mk_word(KIND_END, '0, '0, ERR_NONE));
			end
			default: ;
		endcase
		if (run_q.size() > 0)
			run_q[run_q.size()-1].last = 1'b1;
	endfunction

	function automatic void add_tok(logic [2:0] m, logic [VALUE_W-1:0] v, logic [OPC_W-1:0] opc);
		stim_q.insert(stim_q.size(), mk_tok(m, v, opc));
		if (m <= MODE_END)
			live_cnt++;
	endfunction

	function automatic void add_expr(bit close, bit finish);
		int n_opnd;
		int open;
		n_opnd = $urandom_range(1, 6);
		open   = 0;
		for (int i = 0; i < n_opnd; i++) begin
			while (open < 4 && $urandom_range(0, 3) == 0) begin
				add_tok(MODE_LPAREN, $urandom(), OPC_W'($urandom_range(0, 3)));
				open++;
			end
			add_tok(MODE_VALUE, $urandom(), OPC_W'($urandom_range(0, 3)));
			while (open > 0 && $urandom_range(0, 2) == 0) begin
				add_tok(MODE_RPAREN, $urandom(), OPC_W'($urandom_range(0, 3)));
				open--;
			end
			if (i < n_opnd - 1)
				add_tok(MODE_OPER, $urandom(), OPC_W'($urandom_range(0, 3)));
		end
		while (close && open > 0) begin
			add_tok(MODE_RPAREN, $urandom(), OPC_W'($urandom_range(0, 3)));
			open--;
		end
		if (finish)
			add_tok(MODE_END, $urandom(), OPC_W'($urandom_range(0, 3)));
	endfunction

	function automatic void add_random_run();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			add_expr(1'b1, 1'b1);
		end else if (pick < 75) begin
			n = $urandom_range(1, 4);
			repeat (n) add_tok(3'($urandom_range(0, 7)), $urandom(),
				OPC_W'($urandom_range(0, 3)));
		end else if (pick < 85) begin
			add_expr(1'b0, 1'($urandom_range(0, 1)));
		end else if (pick < 93) begin
			add_expr(1'b1, 1'b0);
			add_tok(MODE_RPAREN, $urandom(), OPC_W'($urandom_range(0, 3)));
		end else begin
			// deep nesting, may run into a full stack
			n = $urandom_range(14, 19);
			repeat (n) begin
				if ($urandom_range(0, 3) != 0)
					add_tok(MODE_LPAREN, $urandom(), OPC_W'($urandom_range(0, 3)));
				else
					add_tok(MODE_OPER, $urandom(), OPC_W'($urandom_range(0, 3)));
			end
			add_tok(MODE_VALUE, $urandom(), OPC_W'($urandom_range(0, 3)));
			add_tok(MODE_END, $urandom(), OPC_W'($urandom_range(0, 3)));
		end
	endfunction

	task automatic report_mismatch(string msg);
		if (err_cnt < 100)
			$display("mismatch at %0t ns: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic feed_tokens(int hold_at);
		int gap;
		bit taken;
		for (int i = 0; i < stim_q.size(); i++) begin
			gap = calm ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			if (i == hold_at)
				hold_req = 1'b1;
			in_valid      <= 1'b1;
			mode          <= stim_q[i].mode;
			operand_value <= stim_q[i].value;
			operator_code <= stim_q[i].opc;
			cur_tok       <= stim_q[i];
			do begin
				@(negedge clk);
				taken = !in_stall;
				@(posedge clk);
			end while (!taken);
		end
		in_valid <= 1'b0;
		stim_q.delete();
		@(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, prio_t data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic write_prios(prio_t p_add, prio_t p_sub, prio_t p_mul, prio_t p_div);
		write_reg(REG_ADD, p_add);
		write_reg(REG_SUB, p_sub);
		write_reg(REG_MUL, p_mul);
		write_reg(REG_DIV, p_div);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		while (postfix_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// prediction on accepted tokens, checking on accepted words
	always @(posedge clk) begin
		word_t w;
		if (arst_n && cfg_wr_en)
			prio_of[cfg_index] = cfg_data;
		if (arst_n && in_valid && !in_stall) begin
			shunt_token(cur_tok);
			if (cur_tok.fixed)
				postfix_q.insert(postfix_q.size(), cur_tok.want);
			else
				foreach (run_q[k]) postfix_q.insert(postfix_q.size(), run_q[k]);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (postfix_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word kind %0d value %h op %0d err %0d",
					out_kind, out_value, out_operator, error_code));
			end else begin
				w = postfix_q.pop_front();
				if (out_kind !== w.kind || out_value !== w.value || out_operator !== w.op ||
						error_code !== w.err || last_of_run !== w.last)
					report_mismatch($sformatf(
						"got %0d/%h/%0d/%0d/%0b want %0d/%h/%0d/%0d/%0b (kind/value/op/err/last)",
						out_kind, out_value, out_operator, error_code, last_of_run,
						w.kind, w.value, w.op, w.err, w.last));
			end
		end
	end

	// receiver
	initial begin
		int gap;
		bit got;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = calm ? 0 : $urandom_range(0, MAX_GAP);
				if (gap > 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do begin
				@(negedge clk);
				got = out_valid;
				@(posedge clk);
			end while (!got);
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		mode          = '0;
		operand_value = '0;
		operator_code = '0;
		cur_tok       = mk_tok(MODE_VALUE, '0, '0);
		calm          = 1'b0;
		hold_req      = 1'b0;
		err_cnt       = 0;
		live_cnt      = 0;
		shunt_depth   = 0;
		for (int r = 0; r < NUM_OPS; r++)
			prio_of[r] = PRIO_RST[r];

		dir_tab = '{
			fixed_row(MODE_VALUE, 32'h0000_0000, OP_ADD, KIND_VALUE, ERR_NONE),
			fixed_row(MODE_VALUE, 32'hffff_ffff, OP_DIV, KIND_VALUE, ERR_NONE),
			fixed_row(MODE_RPAREN, 32'h0, OP_ADD, KIND_ERROR, ERR_UNMATCHED),
			fixed_row(MODE_END, 32'h0, OP_ADD, KIND_END, ERR_NONE),
			row(MODE_RSVD5, 32'haaaa_5555, OP_DIV, 1),
			row(MODE_RSVD6, 32'h5555_aaaa, OP_MUL, 1),
			row(MODE_RSVD7, 32'hffff_ffff, OP_SUB, 1),
			row(MODE_VALUE, 32'h1, OP_ADD, 1),
			row(MODE_OPER, 32'h0, OP_ADD, 1),
			row(MODE_VALUE, 32'h2, OP_ADD, 1),
			row(MODE_OPER, 32'h0, OP_MUL, 1),
			row(MODE_LPAREN, 32'h0, OP_ADD, 1),
			row(MODE_VALUE, 32'h3, OP_ADD, 1),
			row(MODE_OPER, 32'h0, OP_SUB, 1),
			row(MODE_VALUE, 32'h4, OP_ADD, 1),
			row(MODE_RPAREN, 32'h0, OP_ADD, 1),
			row(MODE_OPER, 32'h0, OP_DIV, 1),
			row(MODE_VALUE, 32'h5, OP_ADD, 1),
			row(MODE_END, 32'h0, OP_ADD, 1),
			row(MODE_OPER, 32'h0, OP_SUB, 1),
			row(MODE_RPAREN, 32'h0, OP_ADD, 1),
			row(MODE_LPAREN, 32'h0, OP_ADD, STACK_DEPTH),
			fixed_row(MODE_OPER, 32'h0, OP_MUL, KIND_ERROR, ERR_OVERFLOW),
			fixed_row(MODE_LPAREN, 32'h0, OP_ADD, KIND_ERROR, ERR_OVERFLOW),
			row(MODE_END, 32'h0, OP_ADD, 1)
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[r])
			repeat (dir_tab[r].reps) stim_q.insert(stim_q.size(), dir_tab[r].tok);
		feed_tokens(-1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				settle();
				case (p)
					1: write_prios(4'd0, 4'd0, 4'd0, 4'd0);
					2: write_prios(4'd15, 4'd15, 4'd15, 4'd15);
					3: write_prios(4'd15, 4'd10, 4'd3, 4'd0);
					default: write_prios(PRIO_W'($urandom_range(0, 15)),
						PRIO_W'($urandom_range(0, 15)), PRIO_W'($urandom_range(0, 15)),
						PRIO_W'($urandom_range(0, 15)));
				endcase
			end
			calm     = (p == 3);
			live_cnt = 0;
			while (live_cnt < WORDS_PER_PHASE)
				add_random_run();
			feed_tokens((p == 2) ? 10 : -1);
		end
		calm = 1'b0;
		settle();

		if (err_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/i2p_pkg.sv
hw/rtl/i2p_stack_mem.sv
hw/rtl/i2p_out_q.sv
hw/rtl/infix_to_postfix_converter_core.sv
tb/testbench.sv
